>>> hw/rtl/swtm_pkg.sv
// Shared types and constants for the sliding-window trimmed mean.
// No dependencies; imported by every module of the block.
`default_nettype none
package swtm_pkg;
  localparam int WinDepth   = 30;
  localparam int CntW       = $clog2(WinDepth + 1);
  localparam int SampleW    = 25;
  localparam int PeriodW    = 17;
  localparam int SumW       = SampleW + $clog2(WinDepth + 1);
  localparam int DivCntW    = $clog2(SumW);
  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(16667);

  typedef logic signed [SampleW-1:0] sample_t;

  // One command to all cells at once.
  typedef struct packed {
    logic    del;
    logic    ins;
    sample_t old_val;
    sample_t new_val;
  } cell_cmd_t;

  // floor(n/3) by comparison against multiples of three.
  function automatic logic [CntW-1:0] third(input logic [CntW-1:0] n);
    logic [CntW-1:0] d;
    d = '0;
    for (int k = 1; k <= WinDepth / 3; k++) begin
      if (int'(n) >= 3 * k) d = CntW'(k);
    end
    return d;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/swtm_cell.sv
// One cell of the window: a tap of the age chain and a slot of the sorted row.
// Depends on swtm_pkg.
`default_nettype none
module swtm_cell (
  input  wire                   clk,
  input  swtm_pkg::cell_cmd_t   cmd,
  input  wire                   win,
  input  swtm_pkg::sample_t     ring_prev,
  input  swtm_pkg::sample_t     srt_prev,
  input  swtm_pkg::sample_t     srt_next,
  input  wire                   gt_prev,
  output swtm_pkg::sample_t     ring_q,
  output swtm_pkg::sample_t     srt_q,
  output logic                  gt
);
  import swtm_pkg::*;

  sample_t ring_r, srt_r, srt_nxt;
  logic    gone;

  assign gone   = win && (srt_r >= cmd.old_val);
  assign gt     = !win || (srt_r > cmd.new_val);
  assign ring_q = ring_r;
  assign srt_q  = srt_r;

  always_comb begin
    srt_nxt = srt_r;
    if (cmd.del && gone) srt_nxt = srt_next;          // close the gap
    else if (cmd.ins && gt) srt_nxt = gt_prev ? srt_prev : cmd.new_val;
  end

  always_ff @(posedge clk) begin
    srt_r <= srt_nxt;
    if (cmd.ins) ring_r <= ring_prev;                 // advance age chain
  end
endmodule
`default_nettype wire

>>> hw/rtl/swtm_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on swtm_pkg.
`default_nettype none
module swtm_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [swtm_pkg::SumW-1:0] dividend,
  input  wire [swtm_pkg::CntW-1:0] divisor,
  output logic                     done,
  output logic [swtm_pkg::SumW-1:0] quotient
);
  import swtm_pkg::*;

  logic              busy_r, done_r;
  logic [DivCntW-1:0] cnt_r;
  logic [SumW-1:0]   q_r;
  logic [CntW:0]     rem_r, trial;
  logic [CntW-1:0]   dsr_r;

  assign trial    = {rem_r[CntW-1:0], q_r[SumW-1]};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        q_r    <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        if (trial >= {1'b0, dsr_r}) begin
          rem_r <= trial - {1'b0, dsr_r};
          q_r   <= {q_r[SumW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[SumW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DivCntW'(SumW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/sliding_window_trimmed_mean.sv
// Sliding-window trimmed mean: a row of cells holding the window by age and sorted.
// Depends on swtm_pkg, swtm_cell and swtm_div.
// One word at a time: the next word is taken the cycle after the result is loaded,
// and the load waits while out_stall holds the previous result back.
// Reset empties the window and loads the frame period with 16667; ring contents
// are left as they are and never read before being written.
`default_nettype none
module sliding_window_trimmed_mean (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [7:0]             in_local_advantage,
  input  wire signed [7:0]             in_remote_advantage,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic signed [24:0]           out_trimmed_mean_us,
  output logic [4:0]                   out_valid_count,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire [2:0]                    cfg_paddr,
  input  wire [31:0]                   cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import swtm_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDel  = 3'd2;
  localparam logic [2:0] StIns  = 3'd3;
  localparam logic [2:0] StSum  = 3'd4;
  localparam logic [2:0] StDiv  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]          state_r;
  logic [PeriodW-1:0]  period_r;
  logic signed [7:0]   loc_r, rem_r;
  sample_t             new_r;
  logic [CntW-1:0]     cnt_r, idx_r, drop, stop, kept;
  logic signed [SumW-1:0] acc_r;
  logic                neg_r, div_start_r;
  logic                out_valid_r;
  sample_t             mean_r;
  logic [4:0]          count_out_r;

  // Configuration port: single register, always ready.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {{(32-PeriodW){1'b0}}, period_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= PeriodReset;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0)
      period_r <= cfg_pwdata[PeriodW-1:0];
  end

  // Phase sample: difference times period, halved toward zero.
  logic signed [8:0]  diff;
  logic signed [26:0] prod;
  logic signed [26:0] half;
  assign diff = {loc_r[7], loc_r} - {rem_r[7], rem_r};
  assign prod = 27'(diff) * $signed({10'd0, period_r});
  assign half = (prod + {26'd0, prod[26]}) >>> 1;

  // Cell row.
  cell_cmd_t cmd;
  sample_t   ring_w [WinDepth];
  sample_t   srt_w  [WinDepth];
  logic      gt_w   [WinDepth];

  assign cmd.del     = (state_r == StDel) && (cnt_r == CntW'(WinDepth));
  assign cmd.ins     = (state_r == StIns);
  assign cmd.old_val = ring_w[WinDepth-1];
  assign cmd.new_val = new_r;

  for (genvar i = 0; i < WinDepth; i++) begin : g_cell
    swtm_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .win       (CntW'(i) < cnt_r),
      .ring_prev ((i == 0) ? new_r : ring_w[(i == 0) ? 0 : i-1]),
      .srt_prev  ((i == 0) ? new_r : srt_w[(i == 0) ? 0 : i-1]),
      .srt_next  ((i == WinDepth-1) ? srt_w[i] : srt_w[(i == WinDepth-1) ? i : i+1]),
      .gt_prev   ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i-1]),
      .ring_q    (ring_w[i]),
      .srt_q     (srt_w[i]),
      .gt        (gt_w[i])
    );
  end

  assign drop = third(cnt_r);
  assign stop = cnt_r - drop;
  assign kept = cnt_r - {drop[CntW-2:0], 1'b0};

  // Divider on magnitudes; sign restored afterwards for truncation toward zero.
  logic            div_done;
  logic [SumW-1:0] quot, mag;
  assign mag = acc_r[SumW-1] ? SumW'(-acc_r) : SumW'(acc_r);

  swtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (mag),
    .divisor  (kept),
    .done     (div_done),
    .quotient (quot)
  );

  assign in_stall            = (state_r != StIdle);
  assign out_valid           = out_valid_r;
  assign out_trimmed_mean_us = mean_r;
  assign out_valid_count     = count_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      // register the divider start pulse from the last cycle of the sum
      div_start_r <= (state_r == StSum) && (idx_r >= drop) && (idx_r >= stop);
      if (out_valid_r && !out_stall && state_r != StOut) out_valid_r <= 1'b0;
      case (state_r)
        StIdle: if (in_valid) begin
          loc_r   <= in_local_advantage;
          rem_r   <= in_remote_advantage;
          state_r <= StMul;
        end
        StMul: begin
          new_r   <= half[SampleW-1:0];
          state_r <= StDel;
        end
        StDel: begin
          // drop the oldest sample from the sorted row when the window is full
          if (cmd.del) cnt_r <= cnt_r - 1'b1;
          state_r <= StIns;
        end
        StIns: begin
          cnt_r   <= cnt_r + 1'b1;
          state_r <= StSum;
          idx_r   <= '0;
          acc_r   <= '0;
        end
        StSum: begin
          if (idx_r < drop) idx_r <= drop;
          else if (idx_r < stop) begin
            acc_r <= acc_r + SumW'(srt_w[idx_r]);
            idx_r <= idx_r + 1'b1;
          end else begin
            neg_r   <= acc_r[SumW-1];
            state_r <= StDiv;
          end
        end
        StDiv: if (div_done) state_r <= StOut;
        StOut: if (!out_valid_r || !out_stall) begin
          mean_r      <= neg_r ? SampleW'(-quot) : SampleW'(quot);
          count_out_r <= 5'(cnt_r);
          out_valid_r <= 1'b1;
          state_r     <= StIdle;
        end
        default: state_r <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> verif/sliding_window_trimmed_mean_tb.sv
// Self-checking testbench for the sliding-window trimmed mean block.
// Depends on swtm_pkg and the sliding_window_trimmed_mean RTL.
`default_nettype none
module sliding_window_trimmed_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swtm_pkg::*;

  localparam int RegFramePeriod = 0;
  localparam int CycleLimit     = 1500000;

  typedef struct packed {
    logic signed [7:0] loc;
    logic signed [7:0] rem;
  } adv_word_t;

  typedef struct packed {
    logic signed [24:0] mean;
    logic [4:0]         cnt;
  } mean_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [7:0] in_local_advantage = '0;
  logic signed [7:0] in_remote_advantage = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [24:0] out_trimmed_mean_us;
  logic [4:0] out_valid_count;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sliding_window_trimmed_mean i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_local_advantage(in_local_advantage), .in_remote_advantage(in_remote_advantage),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_trimmed_mean_us(out_trimmed_mean_us), .out_valid_count(out_valid_count),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: own copy of the window and the period.
  logic signed [24:0] win_samples [WinDepth];
  int unsigned        win_wr_pos;
  int unsigned        win_fill;
  logic [16:0]        period_us;

  adv_word_t  pending_words[$];
  mean_word_t expected_means[$];
  int         err_count = 0;
  longint     cycle_count = 0;
  bit         hold_sender = 1'b0;   // sender pauses while set
  bit         long_hold = 1'b0;     // receiver holds off while set

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // Form the sample, insert it, sort the held samples, trim and average.
  function automatic mean_word_t predict_mean(input adv_word_t w);
    longint     srt [WinDepth];
    longint     sample, sum, v;
    int         n, drop, j;
    mean_word_t r;
    sample = ((longint'(w.loc) - longint'(w.rem)) * longint'(period_us)) / 2;
    win_samples[win_wr_pos] = 25'(sample);
    win_wr_pos = (win_wr_pos + 1) % WinDepth;
    if (win_fill < WinDepth) win_fill++;
    n = win_fill;
    for (int i = 0; i < n; i++) srt[i] = longint'(win_samples[i]);
    for (int i = 1; i < n; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    drop = n / 3;
    sum = 0;
    for (int i = drop; i < n - drop; i++) sum += srt[i];
    r.mean = 25'(sum / longint'(n - 2 * drop));
    r.cnt = 5'(n);
    return r;
  endfunction

  // Driver: draw a gap, then offer the oldest pending word until taken.
  int send_gap = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_means.push_back(predict_mean(pending_words.pop_front()));
        send_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_sender) begin
        in_valid <= 1'b1;
        in_local_advantage <= pending_words[0].loc;
        in_remote_advantage <= pending_words[0].rem;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result, then draw the next stall.
  int recv_gap = 0;
  always @(posedge clk) begin
    mean_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_means.size() == 0) begin
          report_mismatch("unexpected word", out_trimmed_mean_us, 0);
        end else begin
          want = expected_means.pop_front();
          if (out_trimmed_mean_us !== want.mean)
            report_mismatch("trimmed_mean_us", out_trimmed_mean_us, want.mean);
          if (out_valid_count !== want.cnt)
            report_mismatch("valid_count", out_valid_count, want.cnt);
        end
        recv_gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  initial begin
    wait (long_hold);
    repeat (3000) @(posedge clk);
    long_hold = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_period(input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 3'(4 * RegFramePeriod);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    period_us = value[16:0];
  endtask

  // Wait until the block has drained, plus its latency.
  task automatic drain;
    while (pending_words.size() > 0 || in_valid || expected_means.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic adv_word_t rand_word();
    adv_word_t w;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // realistic small advantages
      w.loc = 8'($signed($urandom_range(0, 16)) - 8);
      w.rem = 8'($signed($urandom_range(0, 16)) - 8);
    end else if (kind < 8) begin
      w.loc = 8'($urandom);
      w.rem = 8'($urandom);
    end else begin
      w.loc = ($urandom_range(0, 1) != 0) ? 8'sh7f : 8'sh80;
      w.rem = ($urandom_range(0, 1) != 0) ? 8'sh7f : 8'sh80;
    end
    return w;
  endfunction

  task automatic push_word(input logic signed [7:0] l, input logic signed [7:0] r);
    adv_word_t w;
    w.loc = l;
    w.rem = r;
    pending_words.push_back(w);
  endtask

  logic [16:0] periods [6] = '{17'd16667, 17'd1, 17'd0, 17'h1ffff, 17'd100000, 17'd33333};

  initial begin
    win_wr_pos = 0;
    win_fill = 0;
    period_us = PeriodReset;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset period, field extremes, equal advantages.
    push_word(8'sh7f, 8'sh80);
    push_word(8'sh80, 8'sh7f);
    push_word(8'sd0, 8'sd0);
    push_word(8'sd3, 8'sd3);
    push_word(-8'sd1, 8'sd0);
    push_word(8'sd1, 8'sd0);
    push_word(8'sh55, 8'shaa);
    push_word(8'shaa, 8'sh55);
    drain();

    // Zero period: every sample zero.
    write_period(32'd0);
    for (int i = 0; i < 4; i++) push_word(8'sh7f, 8'sh80);
    drain();

    // Widest period with extreme inputs of alternating sign.
    write_period(32'h1ffff);
    for (int i = 0; i < 10; i++) push_word((i % 2) ? 8'sh7f : 8'sh80, (i % 2) ? 8'sh80 : 8'sh7f);
    drain();

    // Receiver holds off while the sender keeps offering words.
    long_hold = 1'b1;
    for (int i = 0; i < 60; i++) pending_words.push_back(rand_word());
    drain();

    // Random phases across several periods.
    for (int ph = 0; ph < 12; ph++) begin
      write_period((ph < 6) ? 32'(periods[ph]) : 32'($urandom_range(1, 131071)));
      for (int i = 0; i < 100; i++) pending_words.push_back(rand_word());
      if (ph == 5) begin
        while (expected_means.size() > 0 || pending_words.size() > 40) @(posedge clk);
        // Sender pauses until every expected word has come.
        hold_sender = 1'b1;
        while (in_valid || expected_means.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
